// File: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression on every clock edge outside reset.
`define DHAM_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("dham check failed");

// Check that an expression holds in the cycle after a trigger.
`define DHAM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("dham check failed");

`endif

// File: rtl/core/dham_pkg.sv
package dham_pkg;

    localparam int unsigned MAX_DEVICES = 8;
    localparam int unsigned DEV_W       = 3;
    localparam int unsigned CNT_W       = 4;

    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_HEARTBEAT = 3'd1;
    localparam logic [2:0] OP_REGISTER  = 3'd2;
    localparam logic [2:0] OP_ENABLE    = 3'd3;
    localparam logic [2:0] OP_DISABLE   = 3'd4;

    localparam logic [2:0] REG_SCAN_PERIOD  = 3'd0;
    localparam logic [2:0] REG_BURST_PERIOD = 3'd1;
    localparam logic [2:0] REG_BEEP_ON      = 3'd2;
    localparam logic [2:0] REG_BEEP_OFF     = 3'd3;
    localparam logic [2:0] REG_SOUND_ENABLE = 3'd4;

    localparam logic [1:0] LED_UNSET = 2'd0;
    localparam logic [1:0] LED_OK    = 2'd1;
    localparam logic [1:0] LED_RED   = 2'd2;
    localparam logic [1:0] LED_DARK  = 2'd3;

    localparam logic [3:0] NO_DEVICE = 4'd8;
    localparam logic [7:0] TIE_START = 8'hFF;

    localparam logic [9:0]  RST_SCAN_PERIOD  = 10'd10;
    localparam logic [15:0] RST_BURST_PERIOD = 16'd2000;
    localparam logic [15:0] RST_BEEP_ON      = 16'd100;
    localparam logic [15:0] RST_BEEP_OFF     = 16'd100;

    localparam int unsigned PARAM_W = 32;

    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  device;
        logic [15:0] hb_limit;
        logic [7:0]  level;
        logic [7:0]  beep_count;
        logic        enable_flag;
    } t_in_req;

    typedef struct packed {
        logic [7:0] offline_mask;
        logic [3:0] alarm_device;
        logic       buzzer_on;
        logic [1:0] led_color;
        logic [3:0] assigned_index;
    } t_out_req;

    typedef struct packed {
        logic [15:0] hb_limit;
        logic [7:0]  level;
        logic [7:0]  beeps;
    } t_dev_param;

endpackage

// File: rtl/core/dham_ram.sv
module dham_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/device_heartbeat_alarm_monitor_core.sv
// Heartbeat alarm monitor for up to eight devices. Each request carries an op:
// tick, heartbeat, register, enable or disable, and every request gives exactly
// one result with the offline mask, the device chosen for the alarm at the last
// scan, the buzzer and LED drive, and the index handed out by a register
// request (8 otherwise or when the table is full). The device table (last
// heartbeat time, timeout, level, beep count) sits in two single-port-write
// memories with a registered read. A tick scans the table: it reads one table
// entry per cycle through the memory read port and compares it once the read
// data arrives; then the alarm choice settles, the beep sequencer steps and the
// result loads. Only one request is in flight at a time; the result register
// lets the next request in while a result still waits to be taken. Times wrap
// at 32 bits. Settings are written through the APB port at byte addresses 0,
// 4, 8, 12 and 16 (scan period, burst period, beep on time, beep off time,
// sound enable); the user must write them only while the block is idle, and
// the block itself does not enforce this.
module device_heartbeat_alarm_monitor_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  dham_pkg::t_in_req i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output dham_pkg::t_out_req o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SEL,
        S_SEQ,
        S_OUT
    } t_state;

    t_state r_state;

    logic [9:0]  r_scan_period;
    logic [15:0] r_burst_period;
    logic [15:0] r_beep_on;
    logic [15:0] r_beep_off;
    logic        r_sound_enable;

    logic [31:0] r_clock;
    logic [dham_pkg::MAX_DEVICES-1:0] r_enabled;
    logic [dham_pkg::MAX_DEVICES-1:0] r_offline;
    logic [dham_pkg::CNT_W-1:0] r_count;
    logic [7:0]  r_requested;
    logic [3:0]  r_selected;
    logic [31:0] r_period_start;
    logic [31:0] r_beep_start;
    logic [7:0]  r_beeps_left;
    logic        r_buzzer;
    logic [1:0]  r_led;
    logic [3:0]  r_assigned;

    logic [dham_pkg::CNT_W-1:0] r_idx;
    logic                       r_ev_valid;
    logic [dham_pkg::DEV_W-1:0] r_ev_idx;
    logic [7:0]  r_best_level;
    logic [7:0]  r_best_beeps;
    logic [3:0]  r_pick;
    logic [31:0] r_period_age;
    logic [31:0] r_beep_age;

    logic               r_out_valid;
    dham_pkg::t_out_req r_out;

    logic        in_acc;
    logic        cfg_wr;
    logic        dev_known;
    logic        table_full;
    logic        ls_we;
    logic        par_we;
    logic [dham_pkg::DEV_W-1:0] ls_waddr;
    logic [31:0] ls_rdata;
    dham_pkg::t_dev_param par_wdata;
    dham_pkg::t_dev_param par_rdata;
    logic [31:0] ev_age;
    logic        ev_late;
    logic        scan_issue;
    logic [16:0] beep_span;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;

    assign dev_known  = ({1'b0, i_in.device} < r_count);
    assign table_full = (r_count >= dham_pkg::CNT_W'(dham_pkg::MAX_DEVICES));

    always_comb begin
        ls_we     = in_acc && (((i_in.op == dham_pkg::OP_HEARTBEAT) && dev_known)
                    || ((i_in.op == dham_pkg::OP_REGISTER) && !table_full));
        par_we    = in_acc && (i_in.op == dham_pkg::OP_REGISTER) && !table_full;
        ls_waddr  = (i_in.op == dham_pkg::OP_REGISTER) ? r_count[dham_pkg::DEV_W-1:0]
                                                       : i_in.device;
        par_wdata = '{hb_limit: i_in.hb_limit, level: i_in.level,
                      beeps: i_in.beep_count};
    end

    dham_ram #(
        .WIDTH(32),
        .DEPTH(dham_pkg::MAX_DEVICES)
    ) u_last_seen (
        .i_clk  (i_clk),
        .i_we   (ls_we),
        .i_waddr(ls_waddr),
        .i_wdata(r_clock),
        .i_raddr(r_idx[dham_pkg::DEV_W-1:0]),
        .o_rdata(ls_rdata)
    );

    dham_ram #(
        .WIDTH(dham_pkg::PARAM_W),
        .DEPTH(dham_pkg::MAX_DEVICES)
    ) u_params (
        .i_clk  (i_clk),
        .i_we   (par_we),
        .i_waddr(r_count[dham_pkg::DEV_W-1:0]),
        .i_wdata(par_wdata),
        .i_raddr(r_idx[dham_pkg::DEV_W-1:0]),
        .o_rdata(par_rdata)
    );

    assign ev_age     = r_clock - ls_rdata;
    assign ev_late    = (ev_age > {16'd0, par_rdata.hb_limit});
    assign scan_issue = (r_idx < r_count);
    assign beep_span  = {1'b0, r_beep_on} + {1'b0, r_beep_off};

    always_comb begin
        unique case (paddr[4:2])
            dham_pkg::REG_SCAN_PERIOD:  prdata = {22'd0, r_scan_period};
            dham_pkg::REG_BURST_PERIOD: prdata = {16'd0, r_burst_period};
            dham_pkg::REG_BEEP_ON:      prdata = {16'd0, r_beep_on};
            dham_pkg::REG_BEEP_OFF:     prdata = {16'd0, r_beep_off};
            dham_pkg::REG_SOUND_ENABLE: prdata = {31'd0, r_sound_enable};
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_scan_period  <= dham_pkg::RST_SCAN_PERIOD;
            r_burst_period <= dham_pkg::RST_BURST_PERIOD;
            r_beep_on      <= dham_pkg::RST_BEEP_ON;
            r_beep_off     <= dham_pkg::RST_BEEP_OFF;
            r_sound_enable <= 1'b1;
            r_clock        <= 32'd0;
            r_enabled      <= '0;
            r_offline      <= '0;
            r_count        <= '0;
            r_requested    <= 8'd0;
            r_selected     <= dham_pkg::NO_DEVICE;
            r_period_start <= 32'd0;
            r_beep_start   <= 32'd0;
            r_beeps_left   <= 8'd0;
            r_buzzer       <= 1'b0;
            r_led          <= dham_pkg::LED_UNSET;
            r_assigned     <= dham_pkg::NO_DEVICE;
            r_idx          <= '0;
            r_ev_valid     <= 1'b0;
            r_ev_idx       <= '0;
            r_best_level   <= 8'd0;
            r_best_beeps   <= dham_pkg::TIE_START;
            r_pick         <= dham_pkg::NO_DEVICE;
            r_out_valid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[4:2])
                    dham_pkg::REG_SCAN_PERIOD:  r_scan_period  <= pwdata[9:0];
                    dham_pkg::REG_BURST_PERIOD: r_burst_period <= pwdata[15:0];
                    dham_pkg::REG_BEEP_ON:      r_beep_on      <= pwdata[15:0];
                    dham_pkg::REG_BEEP_OFF:     r_beep_off     <= pwdata[15:0];
                    dham_pkg::REG_SOUND_ENABLE: r_sound_enable <= pwdata[0];
                    default: ;
                endcase
            end

            if ((r_state == S_OUT) && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_assigned <= ((i_in.op == dham_pkg::OP_REGISTER) && !table_full)
                                      ? r_count : dham_pkg::NO_DEVICE;
                        r_state    <= (i_in.op == dham_pkg::OP_TICK) ? S_SCAN : S_OUT;
                        unique case (i_in.op)
                            dham_pkg::OP_TICK: begin
                                r_clock      <= r_clock + {22'd0, r_scan_period};
                                r_idx        <= '0;
                                r_ev_valid   <= 1'b0;
                                r_best_level <= 8'd0;
                                r_best_beeps <= dham_pkg::TIE_START;
                                r_pick       <= dham_pkg::NO_DEVICE;
                            end
                            dham_pkg::OP_REGISTER: begin
                                if (!table_full) begin
                                    r_enabled[r_count[dham_pkg::DEV_W-1:0]] <=
                                        i_in.enable_flag;
                                    r_offline[r_count[dham_pkg::DEV_W-1:0]] <= 1'b1;
                                    r_count    <= r_count + dham_pkg::CNT_W'(1);
                                end
                            end
                            dham_pkg::OP_ENABLE: begin
                                if (dev_known) begin
                                    r_enabled[i_in.device] <= 1'b1;
                                end
                            end
                            dham_pkg::OP_DISABLE: begin
                                if (dev_known) begin
                                    r_enabled[i_in.device] <= 1'b0;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SCAN: begin
                    r_ev_valid <= scan_issue;
                    r_ev_idx   <= r_idx[dham_pkg::DEV_W-1:0];
                    if (scan_issue) begin
                        r_idx <= r_idx + dham_pkg::CNT_W'(1);
                    end
                    if (r_ev_valid && r_enabled[r_ev_idx]) begin
                        r_offline[r_ev_idx] <= ev_late;
                        if (ev_late) begin
                            if (par_rdata.level > r_best_level) begin
                                r_best_level <= par_rdata.level;
                                r_best_beeps <= par_rdata.beeps;
                                r_pick       <= {1'b0, r_ev_idx};
                            end else if ((par_rdata.level == r_best_level)
                                         && (par_rdata.beeps != 8'd0)
                                         && ((r_best_beeps == 8'd0)
                                             || (par_rdata.beeps < r_best_beeps))) begin
                                r_best_beeps <= par_rdata.beeps;
                                r_pick       <= {1'b0, r_ev_idx};
                            end
                        end
                    end
                    if (!scan_issue && !r_ev_valid) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    r_selected   <= r_pick;
                    r_period_age <= r_clock - r_period_start;
                    r_beep_age   <= r_clock - r_beep_start;
                    if (r_pick != dham_pkg::NO_DEVICE) begin
                        r_requested <= r_best_beeps;
                    end else begin
                        r_requested <= 8'd0;
                        r_buzzer    <= 1'b0;
                        r_led       <= dham_pkg::LED_OK;
                    end
                    r_state <= S_SEQ;
                end
                S_SEQ: begin
                    if (r_period_age > {16'd0, r_burst_period}) begin
                        r_beeps_left   <= r_requested;
                        r_period_start <= r_clock;
                        r_beep_start   <= r_clock;
                    end else if (r_beeps_left != 8'd0) begin
                        if (r_beep_age < {16'd0, r_beep_on}) begin
                            r_buzzer <= r_sound_enable;
                            r_led    <= dham_pkg::LED_RED;
                        end else if (r_beep_age < {15'd0, beep_span}) begin
                            r_buzzer <= 1'b0;
                            r_led    <= dham_pkg::LED_DARK;
                        end else begin
                            r_beeps_left <= r_beeps_left - 8'd1;
                            r_beep_start <= r_clock;
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_out_valid || !i_out_stall)) begin
            r_out <= '{offline_mask:   8'(r_offline),
                       alarm_device:   r_selected,
                       buzzer_on:      r_buzzer,
                       led_color:      r_led,
                       assigned_index: r_assigned};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `DHAM_ASSERT(a_count_bound, r_count <= dham_pkg::CNT_W'(dham_pkg::MAX_DEVICES))
    `DHAM_ASSERT(a_offline_registered, (r_offline >> r_count) == '0)
    `DHAM_ASSERT_NEXT(a_tick_scans, in_acc && (i_in.op == dham_pkg::OP_TICK),
                      r_state == S_SCAN)
    `DHAM_ASSERT(a_eval_in_scan, !r_ev_valid
                 || ((r_state == S_SCAN) && ({1'b0, r_ev_idx} < r_count)))
    `DHAM_ASSERT(a_pick_registered, (r_pick == dham_pkg::NO_DEVICE) || (r_pick < r_count))

endmodule
